>>> rtl/sldf_pkg.sv
// Shared types and constants for the sync, length and checksum deframer.
`default_nettype none

package sldf_pkg;

   // Number of head bytes, up to and including the length byte.
   localparam int HEAD_BYTES = 7;

   // Width of the configuration register index.
   localparam int CSR_IDX_W = 2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH  = 2'd2;

   // Configuration reset values.
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hFF;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'hAA;
   localparam logic [7:0] MIN_LENGTH_RESET  = 8'd9;

   // Frame status codes carried on the final byte.
   localparam logic [1:0] ST_MID  = 2'd0;
   localparam logic [1:0] ST_GOOD = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // Scan phase of the front end.
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   // Live configuration.
   typedef struct packed {
      logic [7:0] sync_first;
      logic [7:0] sync_second;
      logic [7:0] min_length;
   } cfg_type;

   // One queued command: a whole head to release, or a single frame byte.
   typedef struct packed {
      logic                         is_head;
      logic [HEAD_BYTES-1:0][7:0]   head;
      logic [7:0]                   data;
      logic                         last;
      logic [1:0]                   status;
   } cmd_type;

   // Push side of the command queue.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

endpackage

`default_nettype wire

>>> rtl/sldf_front.sv
// Front end: sync hunt, head capture, length check, checksum and command issue.
`default_nettype none

module sldf_front (
   input  wire                   clock,
   input  wire                   reset,
   input  sldf_pkg::cfg_type     cfg,
   input  wire                   in_accept,
   input  wire  [7:0]            in_data,
   output sldf_pkg::push_type    push
);
   import sldf_pkg::*;

   phase_type                   phase_ff, phase_in;
   logic                        prev_ff, prev_in;
   logic [7:0]                  pos_ff, pos_in;
   logic [7:0]                  len_ff, len_in;
   logic [7:0]                  sum_ff, sum_in;
   logic [7:0]                  exp_ff, exp_in;
   logic [HEAD_BYTES-1:0][7:0]  win_ff, win_in;

   // Rescan result of head bytes two to six after a short length.
   phase_type                   rs_phase;
   logic                        rs_prev;
   logic [2:0]                  rs_pos;
   logic [HEAD_BYTES-1:0][7:0]  rs_win;

   logic [7:0]                  min_eff;
   logic [8:0]                  pos9;
   logic [8:0]                  len9;
   logic [7:0]                  body_sum;
   logic [7:0]                  body_exp;
   logic [7:0]                  head_sum;

   // A minimum below one byte past the head acts as one byte past the head.
   assign min_eff = (cfg.min_length < 8'(HEAD_BYTES + 1)) ? 8'(HEAD_BYTES + 1)
                                                          : cfg.min_length;

   assign pos9 = {1'b0, pos_ff};
   assign len9 = {1'b0, len_ff};

   // Sum of head bytes two and up that precede the checksum byte.
   assign head_sum = 8'(win_ff[2] + win_ff[3] + win_ff[4] + win_ff[5])
                   + ((in_data >= 8'(HEAD_BYTES + 2)) ? in_data : 8'd0);

   // Body bytes update the sum and capture the checksum byte.
   assign body_sum = (pos9 + 9'd3 <= len9) ? 8'(sum_ff + in_data) : sum_ff;
   assign body_exp = (pos9 + 9'd2 == len9) ? in_data : exp_ff;

   // Hunt again over the held bytes two to five and the length byte, in order.
   always_comb begin : rescan
      phase_type                  ph_v;
      logic                       prev_v;
      logic [2:0]                 pos_v;
      logic [HEAD_BYTES-1:0][7:0] w_v;
      logic [7:0]                 t;
      ph_v   = PH_HUNT;
      prev_v = 1'b0;
      pos_v  = 3'd0;
      w_v    = win_ff;
      t      = 8'd0;
      for (int j = 0; j < HEAD_BYTES - 2; j++) begin
         t = (j == HEAD_BYTES - 3) ? in_data : win_ff[3'(j + 2)];
         if (ph_v == PH_HEAD) begin
            if (pos_v < 3'(HEAD_BYTES - 1)) begin
               w_v[pos_v] = t;
               pos_v      = pos_v + 3'd1;
            end
         end else if (prev_v && t == cfg.sync_second) begin
            w_v[0] = cfg.sync_first;
            w_v[1] = t;
            pos_v  = 3'd2;
            ph_v   = PH_HEAD;
            prev_v = 1'b0;
         end else begin
            prev_v = (t == cfg.sync_first);
         end
      end
      rs_phase = ph_v;
      rs_prev  = prev_v;
      rs_pos   = pos_v;
      rs_win   = w_v;
   end

   // Next state and command issue for an accepted item.
   always_comb begin
      phase_in = phase_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      exp_in   = exp_ff;
      win_in   = win_ff;
      push     = '0;
      if (in_accept) begin
         case (phase_ff)
            PH_HEAD: begin
               if (pos_ff < 8'(HEAD_BYTES - 1)) begin
                  win_in[pos_ff[2:0]] = in_data;
                  pos_in              = pos_ff + 8'd1;
               end else if (in_data < min_eff) begin
                  phase_in = rs_phase;
                  prev_in  = rs_prev;
                  pos_in   = {5'd0, rs_pos};
                  win_in   = rs_win;
               end else begin
                  win_in[HEAD_BYTES-1] = in_data;
                  len_in               = in_data;
                  sum_in               = head_sum;
                  exp_in               = (in_data == 8'(HEAD_BYTES + 1)) ? in_data : 8'd0;
                  pos_in               = 8'(HEAD_BYTES);
                  phase_in             = PH_BODY;
                  prev_in              = 1'b0;
                  push.valid           = 1'b1;
                  push.cmd.is_head     = 1'b1;
                  push.cmd.head        = win_ff;
                  push.cmd.head[HEAD_BYTES-1] = in_data;
               end
            end
            PH_BODY: begin
               sum_in          = body_sum;
               exp_in          = body_exp;
               push.valid      = 1'b1;
               push.cmd.data   = in_data;
               if (pos9 + 9'd1 >= len9) begin
                  push.cmd.last   = 1'b1;
                  push.cmd.status = (body_sum == body_exp) ? ST_GOOD : ST_BAD;
                  phase_in        = PH_HUNT;
                  prev_in         = 1'b0;
                  pos_in          = 8'd0;
               end else begin
                  push.cmd.status = ST_MID;
                  pos_in          = pos_ff + 8'd1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               if (prev_ff && in_data == cfg.sync_second) begin
                  win_in[0] = cfg.sync_first;
                  win_in[1] = in_data;
                  pos_in    = 8'd2;
                  phase_in  = PH_HEAD;
                  prev_in   = 1'b0;
               end else begin
                  prev_in = (in_data == cfg.sync_first);
               end
            end
         endcase
      end
   end

   // Control state is reset; the head window is payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         prev_ff  <= 1'b0;
         pos_ff   <= 8'd0;
         len_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         exp_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         sum_ff   <= sum_in;
         exp_ff   <= exp_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

endmodule

`default_nettype wire

>>> rtl/sldf_queue.sv
// Command queue between the front end and the output sequencer.
`default_nettype none

module sldf_queue #(
   parameter int DEPTH = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  sldf_pkg::push_type    push,
   output logic                  full,
   output logic                  pop_ready,
   output sldf_pkg::cmd_type     pop_cmd,
   input  wire                   pop
);
   import sldf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type              mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_ready = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && pop_ready;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/sldf_back.sv
// Output sequencer: expands queued commands into result items.
`default_nettype none

module sldf_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   cmd_ready,
   input  sldf_pkg::cmd_type     cmd,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte
   output logic                  rsp_tlast,   // frame_last
   output logic [2:0]            rsp_tuser    // [0] frame_first, [2:1] frame_status
);
   import sldf_pkg::*;

   logic                        cur_valid_ff, cur_valid_in;
   logic [HEAD_BYTES-1:0][7:0]  cur_head_ff, cur_head_in;
   logic [2:0]                  idx_ff, idx_in;
   logic                        out_valid_ff, out_valid_in;
   logic [7:0]                  out_data_ff, out_data_in;
   logic                        out_first_ff, out_first_in;
   logic                        out_last_ff, out_last_in;
   logic [1:0]                  out_status_ff, out_status_in;
   logic                        load;

   // The output register takes a new item when empty or being drained.
   assign load = !out_valid_ff || rsp_tready;

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_head_in   = cur_head_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      out_first_in  = out_first_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      pop           = 1'b0;
      if (load) begin
         out_valid_in = 1'b0;
         if (cur_valid_ff) begin
            // Continue a head release, one byte per item.
            out_valid_in  = 1'b1;
            out_data_in   = cur_head_ff[idx_ff];
            out_first_in  = 1'b0;
            out_last_in   = 1'b0;
            out_status_in = ST_MID;
            idx_in        = idx_ff + 3'd1;
            if (idx_ff == 3'(HEAD_BYTES - 1)) begin
               cur_valid_in = 1'b0;
            end
         end else if (cmd_ready) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            if (cmd.is_head) begin
               out_data_in   = cmd.head[0];
               out_first_in  = 1'b1;
               out_last_in   = 1'b0;
               out_status_in = ST_MID;
               cur_head_in   = cmd.head;
               cur_valid_in  = 1'b1;
               idx_in        = 3'd1;
            end else begin
               out_data_in   = cmd.data;
               out_first_in  = 1'b0;
               out_last_in   = cmd.last;
               out_status_in = cmd.status;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_head_ff   <= cur_head_in;
      out_data_ff   <= out_data_in;
      out_first_ff  <= out_first_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_status_ff, out_first_ff};

endmodule

`default_nettype wire

>>> rtl/sync_length_checksum_deframer_top.sv
// Top level of the sync, length and checksum deframer.
//
// The req channel takes one link byte per item on req_tdata. The block hunts
// for the two-byte sync pattern, holds the seven-byte head until the length
// byte (head byte six) is checked, then releases the head as seven items and
// passes later frame bytes straight through on the rsp channel. The final
// byte of a frame carries tlast and a checksum verdict in tuser.
// The csr channel writes sync_first (0), sync_second (1) and min_length (2);
// it is always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. Throughput: one byte per cycle in
// and out while the command queue is not full and rsp_tready is high. Body
// bytes and heads pass through the command queue and then the output register
// before they appear on rsp. The output sequencer releases a head as seven
// items while the command queue (QUEUE_DEPTH commands) absorbs body bytes.
// req_tready drops only when the command queue is full, for instance while
// rsp_tready is held low. Results are never dropped or repeated.
// Reset clears all control state and restores the register defaults
// (0xFF, 0xAA, 9); the first item is accepted in the cycle after reset.
`default_nettype none

module sync_length_checksum_deframer_top #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [7:0]                       req_tdata,   // in_byte
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [7:0]                       rsp_tdata,   // out_byte
   output logic                             rsp_tlast,   // frame_last
   output logic [2:0]                       rsp_tuser,   // [0] frame_first, [2:1] frame_status
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [sldf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [7:0]                       csr_data
);
   import sldf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   push_type  push;
   cmd_type   pop_cmd;
   logic      q_full;
   logic      q_ready;
   logic      pop;
   logic      in_accept;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign in_accept  = req_tvalid && req_tready;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_data;
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_data;
            CSR_MIN_LENGTH:  cfg_in.min_length  = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SYNC_FIRST_RESET;
         cfg_ff.sync_second <= SYNC_SECOND_RESET;
         cfg_ff.min_length  <= MIN_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sldf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_accept (in_accept),
      .in_data   (req_tdata),
      .push      (push)
   );

   sldf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (q_full),
      .pop_ready (q_ready),
      .pop_cmd   (pop_cmd),
      .pop       (pop)
   );

   sldf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_ready  (q_ready),
      .cmd        (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> rtl/sldf_checker.sv
// Port-level checks for the deframer, bound to the top level.
`default_nettype none

module sldf_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata,
   input wire        rsp_tlast,
   input wire [2:0]  rsp_tuser
);
   import sldf_pkg::*;

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only the final byte of a frame carries a verdict, and it always does.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast ? (rsp_tuser[2:1] == ST_GOOD || rsp_tuser[2:1] == ST_BAD)
                                : (rsp_tuser[2:1] == ST_MID)))
      else $error("frame status does not match frame end");

   // The first byte of a frame is never its last.
   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tlast))
      else $error("frame start and end on the same item");

   // A frame start follows a frame end or is the first frame after reset:
   // two starts in a row cannot happen since a head is seven items long.
   a_head_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[0] |=> !(rsp_tvalid && rsp_tuser[0]))
      else $error("frame start repeated within a head");

endmodule

bind sync_length_checksum_deframer_top sldf_checker u_checker (.*);

`default_nettype wire
